// File: rtl/mcpw_pkg.sv
package mcpw_pkg;

  // Event kinds carried on the input tuser
  typedef enum logic [1:0] {
    FUNC_CMD   = 2'd0,
    FUNC_PWM   = 2'd1,
    FUNC_LIMIT = 2'd2,
    FUNC_WDOG  = 2'd3
  } func_t;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PWM_PERIOD      = 2'd0,
    CFG_DUTY_STEP       = 2'd1,
    CFG_WATCHDOG_RELOAD = 2'd2
  } cfg_index_t;

  // Field widths
  localparam int PERIOD_W = 7;
  localparam int STEP_W   = 7;
  localparam int DUTY_W   = 9;
  localparam int BRIDGE_W = 4;
  localparam int CODE_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;

  // Reset values
  localparam logic [PERIOD_W-1:0] PWM_PERIOD_RESET = 7'd100;
  localparam logic [STEP_W-1:0]   DUTY_STEP_RESET  = 7'd30;
  localparam longint unsigned     WATCHDOG_RELOAD_RESET = 64'h7A1200;
  localparam int                  WATCHDOG_WIDTH_DEF    = 32;

  // Bridge codes
  localparam logic [CODE_W-1:0]   CODE_RIGHT = 2'b01;
  localparam logic [CODE_W-1:0]   CODE_LEFT  = 2'b10;
  localparam logic [CODE_W-1:0]   CODE_STOP  = 2'b11;
  localparam logic [BRIDGE_W-1:0] BRIDGE_ALL_STOP = 4'hF;

  // Drive level times step, built from shifts and one add
  function automatic logic [DUTY_W-1:0] duty_of(input logic [1:0] lvl,
                                                 input logic [STEP_W-1:0] step);
    logic [DUTY_W-1:0] s1;
    logic [DUTY_W-1:0] s2;
    s1 = lvl[0] ? DUTY_W'(step) : '0;
    s2 = lvl[1] ? (DUTY_W'(step) << 1) : '0;
    return s1 + s2;
  endfunction

endpackage

// File: rtl/motor_command_pwm_watchdog_core.sv
// A result is registered and appears on m_axis in the cycle after its input transaction.
// Throughput: one event per cycle; s_axis_tready drops only while a result
// waits in the output register and m_axis_tready is low.
// Each event is a single pass through the input decode and the watchdog
// compare/decrement ahead of the result register.
// Reset (rst, synchronous): register defaults, cleared state, full watchdog count.
module motor_command_pwm_watchdog_core #(
  parameter int WATCHDOG_WIDTH = mcpw_pkg::WATCHDOG_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input events
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // rx_byte[7:0], rx_has_data[8], limit_bits[10:9], zero fill
  input  logic [mcpw_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // func[1:0]
  input  logic [mcpw_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
  // Results
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // bridge_bits[3:0], pwm_pin_a[4], pwm_pin_b[5], headlight_on[6], timed_out[7]
  output logic [mcpw_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // Configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mcpw_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mcpw_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import mcpw_pkg::*;

  localparam logic [WATCHDOG_WIDTH-1:0] WdReset = WATCHDOG_WIDTH'(WATCHDOG_RELOAD_RESET);
  localparam logic [WATCHDOG_WIDTH-1:0] WdOne   = WATCHDOG_WIDTH'(1);

  // Configuration registers
  logic [PERIOD_W-1:0]       pwm_period;
  logic [STEP_W-1:0]         duty_step;
  logic [WATCHDOG_WIDTH-1:0] watchdog_reload;

  // Block state
  logic [BYTE_W-1:0]         last_byte;
  logic                      steer_right_flag;
  logic                      steer_left_flag;
  logic [BRIDGE_W-1:0]       bridge_state;
  logic [DUTY_W-1:0]         duty_a;
  logic [DUTY_W-1:0]         duty_b;
  logic [PERIOD_W-1:0]       pwm_count;
  logic [1:0]                pin_levels;
  logic                      light_state;
  logic [WATCHDOG_WIDTH-1:0] watchdog_count;

  logic [BYTE_W-1:0]         last_byte_next;
  logic                      steer_right_flag_next;
  logic                      steer_left_flag_next;
  logic [BRIDGE_W-1:0]       bridge_state_next;
  logic [DUTY_W-1:0]         duty_a_next;
  logic [DUTY_W-1:0]         duty_b_next;
  logic [PERIOD_W-1:0]       pwm_count_next;
  logic [1:0]                pin_levels_next;
  logic                      light_state_next;
  logic [WATCHDOG_WIDTH-1:0] watchdog_count_next;
  logic                      expired;

  // Input field views
  func_t             func;
  logic [BYTE_W-1:0] rx_byte;
  logic              rx_has_data;
  logic [1:0]        limit_bits;
  logic              accept;

  // Command decode helpers
  logic [BYTE_W-1:0]   cmd_byte;
  logic [CODE_W-1:0]   code1;
  logic [CODE_W-1:0]   code1_locked;
  logic [PERIOD_W:0]   count_inc;

  assign func        = func_t'(s_axis_tuser);
  assign rx_byte     = s_axis_tdata[7:0];
  assign rx_has_data = s_axis_tdata[8];
  assign limit_bits  = s_axis_tdata[10:9];

  // Output register frees the input side when empty or being drained
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // Configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period      <= PWM_PERIOD_RESET;
      duty_step       <= DUTY_STEP_RESET;
      watchdog_reload <= WdReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_PWM_PERIOD:      pwm_period      <= cfg_data[PERIOD_W-1:0];
        CFG_DUTY_STEP:       duty_step       <= cfg_data[STEP_W-1:0];
        CFG_WATCHDOG_RELOAD: watchdog_reload <= cfg_data[WATCHDOG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Command byte split with steering lockout on the first bridge code
  assign cmd_byte  = rx_has_data ? rx_byte : last_byte;
  assign code1     = cmd_byte[1:0];
  assign count_inc = {1'b0, pwm_count} + 1'b1;

  always_comb begin
    code1_locked = code1;
    if (code1 == CODE_RIGHT && steer_right_flag) begin
      code1_locked = CODE_STOP;
    end else if (code1 == CODE_LEFT && steer_left_flag) begin
      code1_locked = CODE_STOP;
    end
  end

  // Event handling
  always_comb begin
    last_byte_next        = last_byte;
    steer_right_flag_next = steer_right_flag;
    steer_left_flag_next  = steer_left_flag;
    bridge_state_next     = bridge_state;
    duty_a_next           = duty_a;
    duty_b_next           = duty_b;
    pwm_count_next        = pwm_count;
    pin_levels_next       = pin_levels;
    light_state_next      = light_state;
    watchdog_count_next   = watchdog_count;
    expired               = 1'b0;
    unique case (func)
      FUNC_CMD: begin
        last_byte_next      = cmd_byte;
        bridge_state_next   = {code1_locked, cmd_byte[5:4]};
        duty_a_next         = duty_of(cmd_byte[3:2], duty_step);
        duty_b_next         = duty_of(cmd_byte[7:6], duty_step);
        watchdog_count_next = watchdog_reload;
        light_state_next    = 1'b1;
      end
      FUNC_PWM: begin
        // Wrap past the period; pins follow the new count
        pwm_count_next     = (count_inc > {1'b0, pwm_period}) ? '0
                                                              : count_inc[PERIOD_W-1:0];
        pin_levels_next[0] = DUTY_W'(pwm_count_next) <= duty_a;
        pin_levels_next[1] = DUTY_W'(pwm_count_next) <= duty_b;
      end
      FUNC_LIMIT: begin
        if (limit_bits[1]) begin
          steer_right_flag_next = 1'b0;
          steer_left_flag_next  = 1'b1;
        end else if (limit_bits[0]) begin
          steer_right_flag_next = 1'b1;
          steer_left_flag_next  = 1'b0;
        end else begin
          steer_right_flag_next = 1'b0;
          steer_left_flag_next  = 1'b0;
        end
      end
      FUNC_WDOG: begin
        if (watchdog_count <= WdOne) begin
          expired             = 1'b1;
          watchdog_count_next = watchdog_reload;
          bridge_state_next   = BRIDGE_ALL_STOP;
          duty_a_next         = '0;
          duty_b_next         = '0;
          light_state_next    = 1'b0;
        end else begin
          watchdog_count_next = watchdog_count - WdOne;
        end
      end
      default: ;
    endcase
  end

  // State update on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      last_byte        <= '0;
      steer_right_flag <= 1'b0;
      steer_left_flag  <= 1'b0;
      bridge_state     <= '0;
      duty_a           <= '0;
      duty_b           <= '0;
      pwm_count        <= '0;
      pin_levels       <= '0;
      light_state      <= 1'b0;
      watchdog_count   <= WdReset;
    end else if (accept) begin
      last_byte        <= last_byte_next;
      steer_right_flag <= steer_right_flag_next;
      steer_left_flag  <= steer_left_flag_next;
      bridge_state     <= bridge_state_next;
      duty_a           <= duty_a_next;
      duty_b           <= duty_b_next;
      pwm_count        <= pwm_count_next;
      pin_levels       <= pin_levels_next;
      light_state      <= light_state_next;
      watchdog_count   <= watchdog_count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {expired, light_state_next, pin_levels_next[1], pin_levels_next[0],
                       bridge_state_next};
    end
  end

`ifndef SYNTHESIS
  // An expiry result always shows the motors stopped and the light off
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[7] |->
      m_axis_tdata[3:0] == BRIDGE_ALL_STOP && !m_axis_tdata[6])
    else $error("timed_out result without full stop");

  // Every accepted transaction leaves a pending result
  assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tvalid)
    else $error("accepted event produced no result");

  // The headlight only comes on through a command
  assert property (@(posedge clk) disable iff (rst)
    $rose(light_state) |-> $past(accept) && $past(func) == FUNC_CMD)
    else $error("headlight turned on without a command");

  // A fresh command byte is latched
  assert property (@(posedge clk) disable iff (rst)
    accept && func == FUNC_CMD && rx_has_data |=> last_byte == $past(rx_byte))
    else $error("command byte not latched");
`endif

endmodule

// File: dv/tb_motor_command_pwm_watchdog_core.sv
module tb_motor_command_pwm_watchdog_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mcpw_pkg::*;

  // Unmapped register index, writes to it must be ignored
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;
  localparam int unsigned SINK_HOLD   = 300;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned N_PHASES    = 8;
  localparam int unsigned PHASE_ITEMS = 125;

  // Result fields, lowest bit last
  typedef struct packed {
    logic                timed_out;
    logic                headlight_on;
    logic                pwm_pin_b;
    logic                pwm_pin_a;
    logic [BRIDGE_W-1:0] bridge_bits;
  } motor_out_t;

  // One step of the directed sequence: a register write or an event
  typedef struct {
    bit                     is_reg;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    func_t                  f;
    logic [BYTE_W-1:0]      rx;
    logic                   has;
    logic [1:0]             lim;
    bit                     typed;
    motor_out_t             want;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Traffic control
  logic        idle_on = 1'b1;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned sink_wait = 0;
  int unsigned quiet_cycles = 0;

  // Predicted block state and configuration
  logic [PERIOD_W-1:0]   cur_period;
  logic [STEP_W-1:0]     cur_step;
  logic [31:0]           cur_reload;
  logic [BYTE_W-1:0]     held_byte;
  logic                  right_flag;
  logic                  left_flag;
  logic [BRIDGE_W-1:0]   bridge_q;
  logic [DUTY_W-1:0]     duty_a_q;
  logic [DUTY_W-1:0]     duty_b_q;
  logic [PERIOD_W-1:0]   pwm_cnt;
  logic                  pin_a_q;
  logic                  pin_b_q;
  logic                  light_q;
  logic [31:0]           wdog_cnt;

  motor_out_t  expected_outputs[$];
  plan_row_t   directed_plan[$];
  motor_out_t  got_out;
  motor_out_t  want_out;
  int unsigned events_sent = 0;
  int unsigned results_checked = 0;
  int unsigned expiry_count = 0;
  int unsigned reg_writes = 0;
  int unsigned mismatches = 0;

  motor_command_pwm_watchdog_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap(logic en);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (!en || p < 60) return 0;
    if (p < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advance the predicted state by one event, return the outputs it shows
  function automatic motor_out_t advance_drive(func_t f, logic [BYTE_W-1:0] rx, logic has,
                                               logic [1:0] lim);
    motor_out_t      o;
    logic [CODE_W-1:0] code1;
    logic [7:0]      next_cnt;
    o = '0;
    case (f)
      FUNC_CMD: begin
        if (has) held_byte = rx;
        code1 = held_byte[1:0];
        // steering lockout against the active end switch
        if (code1 == CODE_RIGHT && right_flag) code1 = CODE_STOP;
        else if (code1 == CODE_LEFT && left_flag) code1 = CODE_STOP;
        bridge_q = {code1, held_byte[5:4]};
        duty_a_q = DUTY_W'(held_byte[3:2]) * DUTY_W'(cur_step);
        duty_b_q = DUTY_W'(held_byte[7:6]) * DUTY_W'(cur_step);
        wdog_cnt = cur_reload;
        light_q  = 1'b1;
      end
      FUNC_PWM: begin
        next_cnt = {1'b0, pwm_cnt} + 8'd1;
        if (next_cnt > {1'b0, cur_period}) next_cnt = '0;
        pwm_cnt = next_cnt[PERIOD_W-1:0];
        pin_a_q = (DUTY_W'(pwm_cnt) <= duty_a_q);
        pin_b_q = (DUTY_W'(pwm_cnt) <= duty_b_q);
      end
      FUNC_LIMIT: begin
        // the left-flag switch (lim[1]) wins when both are closed
        left_flag  = lim[1];
        right_flag = !lim[1] && lim[0];
      end
      FUNC_WDOG: begin
        if (wdog_cnt <= 32'd1) begin
          wdog_cnt    = cur_reload;
          bridge_q    = BRIDGE_ALL_STOP;
          duty_a_q    = '0;
          duty_b_q    = '0;
          light_q     = 1'b0;
          o.timed_out = 1'b1;
          expiry_count++;
        end else begin
          wdog_cnt = wdog_cnt - 32'd1;
        end
      end
    endcase
    o.bridge_bits  = bridge_q;
    o.pwm_pin_a    = pin_a_q;
    o.pwm_pin_b    = pin_b_q;
    o.headlight_on = light_q;
    return o;
  endfunction

  task automatic plan_event(func_t f, logic [BYTE_W-1:0] rx, logic has, logic [1:0] lim,
                            bit typed = 1'b0, motor_out_t want = '0);
    plan_row_t r;
    r.is_reg  = 1'b0;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.f       = f;
    r.rx      = rx;
    r.has     = has;
    r.lim     = lim;
    r.typed   = typed;
    r.want    = want;
    directed_plan.push_back(r);
  endtask

  task automatic plan_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    plan_row_t r;
    r.is_reg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    r.f       = FUNC_CMD;
    r.rx      = '0;
    r.has     = 1'b0;
    r.lim     = '0;
    r.typed   = 1'b0;
    r.want    = '0;
    directed_plan.push_back(r);
  endtask

  // Offer one event and record its expected outputs once accepted
  task automatic send_event(func_t f, logic [BYTE_W-1:0] rx, logic has, logic [1:0] lim,
                            bit typed, motor_out_t want);
    motor_out_t  pred;
    int unsigned pause;
    cfg_valid <= 1'b0;
    pause = pick_gap(idle_on);
    if (pause != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, lim, has, rx};
    s_axis_tuser  <= f;
    do @(posedge clk); while (!s_axis_tready);
    pred = advance_drive(f, rx, has, lim);
    expected_outputs.push_back(typed ? want : pred);
    events_sent++;
  endtask

  // Register write, only once every outstanding result has drained
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    s_axis_tvalid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PWM_PERIOD:      cur_period = val[PERIOD_W-1:0];
      CFG_DUTY_STEP:       cur_step   = val[STEP_W-1:0];
      CFG_WATCHDOG_RELOAD: cur_reload = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
  endtask

  // Receiver: random back-pressure plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_wait     <= 0;
    end else if (hold_req && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_done     <= 1'b1;
      sink_wait     <= SINK_HOLD;
    end else if (sink_wait != 0) begin
      m_axis_tready <= 1'b0;
      sink_wait     <= sink_wait - 1;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      sink_wait     <= pick_gap(1'b1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_out = motor_out_t'(m_axis_tdata);
      if (expected_outputs.size() == 0) begin
        note_mismatch("unexpected result", '0, 32'(got_out));
      end else begin
        want_out = expected_outputs.pop_front();
        results_checked++;
        if (got_out.bridge_bits !== want_out.bridge_bits)
          note_mismatch("bridge_bits", 32'(want_out.bridge_bits),
                        32'(got_out.bridge_bits));
        if (got_out.pwm_pin_a !== want_out.pwm_pin_a)
          note_mismatch("pwm_pin_a", 32'(want_out.pwm_pin_a), 32'(got_out.pwm_pin_a));
        if (got_out.pwm_pin_b !== want_out.pwm_pin_b)
          note_mismatch("pwm_pin_b", 32'(want_out.pwm_pin_b), 32'(got_out.pwm_pin_b));
        if (got_out.headlight_on !== want_out.headlight_on)
          note_mismatch("headlight_on", 32'(want_out.headlight_on),
                        32'(got_out.headlight_on));
        if (got_out.timed_out !== want_out.timed_out)
          note_mismatch("timed_out", 32'(want_out.timed_out), 32'(got_out.timed_out));
      end
    end
  end

  // Stall watchdog: ends the run if no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned     r;
    func_t           f;
    logic [BYTE_W-1:0] rx;
    logic            has;
    logic [1:0]      lim;
    logic [6:0]      period_v;
    logic [6:0]      step_v;
    logic [31:0]     reload_v;

    // state after reset
    cur_period = PWM_PERIOD_RESET;
    cur_step   = DUTY_STEP_RESET;
    cur_reload = 32'(WATCHDOG_RELOAD_RESET);
    held_byte  = '0;
    right_flag = 1'b0;
    left_flag  = 1'b0;
    bridge_q   = '0;
    duty_a_q   = '0;
    duty_b_q   = '0;
    pwm_cnt    = '0;
    pin_a_q    = 1'b0;
    pin_b_q    = 1'b0;
    light_q    = 1'b0;
    wdog_cnt   = cur_reload;

    // directed sequence; typed results are plain from reset defaults
    plan_event(FUNC_PWM,   8'h00, 1'b0, 2'd0, 1'b1, 8'h00);
    plan_event(FUNC_LIMIT, 8'h00, 1'b0, 2'd0, 1'b1, 8'h00);
    plan_event(FUNC_CMD,   8'hFF, 1'b1, 2'd0, 1'b1, 8'h4F);
    plan_event(FUNC_PWM,   8'h00, 1'b0, 2'd0, 1'b1, 8'h7F);
    plan_event(FUNC_CMD,   8'h00, 1'b1, 2'd0, 1'b1, 8'h70);
    // no new byte: previous one reused
    plan_event(FUNC_CMD,   8'hFF, 1'b0, 2'd0, 1'b1, 8'h70);
    // lockouts from each end switch, then both switches closed
    plan_event(FUNC_LIMIT, 8'h00, 1'b0, 2'd1);
    plan_event(FUNC_CMD,   8'h01, 1'b1, 2'd0);
    plan_event(FUNC_LIMIT, 8'h00, 1'b0, 2'd2);
    plan_event(FUNC_CMD,   8'h02, 1'b1, 2'd0);
    plan_event(FUNC_LIMIT, 8'h00, 1'b0, 2'd3);
    plan_event(FUNC_CMD,   8'h01, 1'b1, 2'd0);
    // zero period holds the counter at zero
    plan_reg(CFG_PWM_PERIOD, 32'h0);
    plan_event(FUNC_PWM,   8'h00, 1'b0, 2'd0);
    plan_event(FUNC_PWM,   8'h00, 1'b0, 2'd0);
    // largest step and period, full duty
    plan_reg(CFG_DUTY_STEP,  32'hFFFF_FFFF);
    plan_reg(CFG_PWM_PERIOD, 32'hFFFF_FFFF);
    plan_event(FUNC_CMD,   8'hCC, 1'b1, 2'd0);
    plan_event(FUNC_PWM,   8'h00, 1'b0, 2'd0);
    // zero reload: applies on next command, then every tick expires
    plan_reg(CFG_WATCHDOG_RELOAD, 32'h0);
    plan_event(FUNC_WDOG,  8'h00, 1'b0, 2'd0);
    plan_event(FUNC_CMD,   8'hE4, 1'b1, 2'd0);
    plan_event(FUNC_WDOG,  8'h00, 1'b0, 2'd0);
    plan_event(FUNC_WDOG,  8'h00, 1'b0, 2'd0);
    plan_reg(CFG_WATCHDOG_RELOAD, 32'd2);
    plan_event(FUNC_CMD,   8'h5A, 1'b1, 2'd0);
    plan_event(FUNC_WDOG,  8'h00, 1'b0, 2'd0);
    plan_event(FUNC_WDOG,  8'h00, 1'b0, 2'd0);
    plan_event(FUNC_PWM,   8'h00, 1'b0, 2'd0);
    // unmapped index must not disturb anything
    plan_reg(CFG_SPARE_INDEX, 32'h0000_0001);
    plan_reg(CFG_DUTY_STEP, 32'h0);
    plan_reg(CFG_WATCHDOG_RELOAD, 32'hFFFF_FFFF);
    plan_reg(CFG_PWM_PERIOD, 32'h1);
    plan_event(FUNC_CMD,   8'hFF, 1'b1, 2'd0);
    plan_event(FUNC_WDOG,  8'h00, 1'b0, 2'd0);
    plan_event(FUNC_PWM,   8'h00, 1'b0, 2'd0);
    plan_event(FUNC_PWM,   8'h00, 1'b0, 2'd0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_reg)
        write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
      else
        send_event(directed_plan[i].f, directed_plan[i].rx, directed_plan[i].has,
                   directed_plan[i].lim, directed_plan[i].typed, directed_plan[i].want);
    end

    // random phases, each under its own register setting
    for (int unsigned p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin period_v = 7'd1;   step_v = 7'd127; reload_v = 32'd1; end
        1: begin period_v = 7'd127; step_v = 7'd0;   reload_v = 32'hFFFF_FFFF; end
        2: begin period_v = 7'd0;   step_v = 7'($urandom_range(0, 127)); reload_v = 32'd0; end
        default: begin
          period_v = 7'($urandom_range(1, 127));
          step_v   = 7'($urandom_range(0, 127));
          reload_v = $urandom_range(1, 16);
        end
      endcase
      write_reg(CFG_PWM_PERIOD, {25'($urandom()), period_v});
      write_reg(CFG_DUTY_STEP, {25'($urandom()), step_v});
      write_reg(CFG_WATCHDOG_RELOAD, reload_v);
      write_reg(CFG_SPARE_INDEX, $urandom());
      // one stretch with no idling on either side
      idle_on <= (p != 3);

      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold-off while events keep coming
        if (p == 4 && n == 20) hold_req <= 1'b1;
        // sender pauses until every result is back
        if (p == 6 && n == 60) begin
          s_axis_tvalid <= 1'b0;
          do @(posedge clk); while (expected_outputs.size() != 0);
        end
        r = $urandom_range(0, 99);
        if (r < 25)      f = FUNC_CMD;
        else if (r < 60) f = FUNC_PWM;
        else if (r < 72) f = FUNC_LIMIT;
        else             f = FUNC_WDOG;
        rx  = BYTE_W'($urandom());
        has = ($urandom_range(0, 9) != 0);
        lim = 2'($urandom());
        send_event(f, rx, has, lim, 1'b0, '0);
      end
    end

    // drain
    s_axis_tvalid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Run covered %0d events under %0d register writes, %0d results checked,",
             events_sent, reg_writes, results_checked);
    $display("including %0d watchdog expiries; %0d mismatches.", expiry_count, mismatches);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
